### sv/panel_power_window_monitor_defines.svh
// Assertion macros shared by the panel power window monitor RTL.
`ifndef PANEL_POWER_WINDOW_MONITOR_DEFINES_SVH
`define PANEL_POWER_WINDOW_MONITOR_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define PPWM_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define PPWM_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define PPWM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/ppwm_pkg.sv
// Types and constants shared by the panel power window monitor modules.
package ppwm_pkg;

   localparam int DefaultWindowSamples = 5;

   localparam int CodeWidth     = 12;
   localparam int RegWidth      = 16;
   localparam int PowerWidth    = 23;
   localparam int FaultWidth    = 2;
   localparam int IndexWidth    = 6;
   localparam int SumWidth      = 29;
   localparam int CsrIndexWidth = 2;
   localparam int MulWidth      = 32;
   localparam int ProductWidth  = 64;

   localparam logic [RegWidth-1:0] ResetFullScaleVolt = 16'd48000;
   localparam logic [RegWidth-1:0] ResetFullScaleAmp  = 16'd20000;
   localparam logic [RegWidth-1:0] ResetVoltLimit     = 16'd40000;
   localparam logic [RegWidth-1:0] ResetAmpLimit      = 16'd15000;

   // Scaling divides by 4095 = 2^12 - 1 with rounding by adding half the divisor.
   localparam int AdcShift = 12;
   localparam logic [AdcShift-1:0] AdcDivisor = 12'd4095;
   localparam logic [AdcShift-1:0] AdcHalf    = 12'd2047;

   // Exact floor division by 1000 for any 32-bit product: multiply and shift.
   localparam logic [MulWidth-1:0] Recip1000      = 32'd2199023256;
   localparam int                  Recip1000Shift = 41;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_FULL_SCALE_VOLT = 2'd0,
      CSR_FULL_SCALE_AMP  = 2'd1,
      CSR_VOLT_LIMIT      = 2'd2,
      CSR_AMP_LIMIT       = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_V,
      ST_MUL_A,
      ST_DIV_V,
      ST_DIV_A,
      ST_MUL_P,
      ST_MUL_R,
      ST_ACC,
      ST_AVG,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MSEL_VOLT,
      MSEL_AMP,
      MSEL_POWER,
      MSEL_RECIP,
      MSEL_AVERAGE
   } mul_sel_type;

   typedef struct packed {
      logic        capture;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        load_mv;
      logic        load_ma;
      logic        accumulate;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      logic window_last;
      logic rsp_free;
   } sts_type;

endpackage

### sv/ppwm_channels.sv
// Handshake channel interfaces for ADC sample requests and power results.
interface ppwm_req_if;
   logic                           valid;
   logic                           ready;
   logic [ppwm_pkg::CodeWidth-1:0] raw_volt_code;
   logic [ppwm_pkg::CodeWidth-1:0] raw_amp_code;

   modport source (output valid, output raw_volt_code, output raw_amp_code, input ready);
   modport sink (input valid, input raw_volt_code, input raw_amp_code, output ready);
endinterface

interface ppwm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ppwm_pkg::RegWidth-1:0]    volt_mv;
   logic [ppwm_pkg::RegWidth-1:0]    amp_ma;
   logic [ppwm_pkg::PowerWidth-1:0]  sample_power_mw;
   logic [ppwm_pkg::PowerWidth-1:0]  average_power_mw;
   logic [ppwm_pkg::FaultWidth-1:0]  fault_code;
   logic                             window_end;

   modport source (
      output valid, output volt_mv, output amp_ma, output sample_power_mw,
      output average_power_mw, output fault_code, output window_end, input ready
   );
   modport sink (
      input valid, input volt_mv, input amp_ma, input sample_power_mw,
      input average_power_mw, input fault_code, input window_end, output ready
   );
endinterface

### sv/ppwm_ctrl.sv
// Sequencer that steps one sample pair through the shared multiplier datapath.
module ppwm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output ppwm_pkg::cmd_type cmd,
   input  ppwm_pkg::sts_type sts
);

   ppwm_pkg::state_type state_ff;
   ppwm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppwm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ppwm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ppwm_pkg::ST_MUL_V;
            end
         end
         ppwm_pkg::ST_MUL_V: state_in = ppwm_pkg::ST_MUL_A;
         ppwm_pkg::ST_MUL_A: state_in = ppwm_pkg::ST_DIV_V;
         ppwm_pkg::ST_DIV_V: state_in = ppwm_pkg::ST_DIV_A;
         ppwm_pkg::ST_DIV_A: state_in = ppwm_pkg::ST_MUL_P;
         ppwm_pkg::ST_MUL_P: state_in = ppwm_pkg::ST_MUL_R;
         ppwm_pkg::ST_MUL_R: state_in = ppwm_pkg::ST_ACC;
         ppwm_pkg::ST_ACC: begin
            state_in = sts.window_last ? ppwm_pkg::ST_AVG : ppwm_pkg::ST_OUT;
         end
         ppwm_pkg::ST_AVG: state_in = ppwm_pkg::ST_OUT;
         ppwm_pkg::ST_OUT: begin
            if (sts.rsp_free) begin
               state_in = ppwm_pkg::ST_IDLE;
            end
         end
         default: state_in = ppwm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = ppwm_pkg::MSEL_VOLT;
      req_ready   = 1'b0;
      case (state_ff)
         ppwm_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ppwm_pkg::ST_MUL_V: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ppwm_pkg::MSEL_VOLT;
         end
         ppwm_pkg::ST_MUL_A: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ppwm_pkg::MSEL_AMP;
         end
         ppwm_pkg::ST_DIV_V: cmd.load_mv = 1'b1;
         ppwm_pkg::ST_DIV_A: cmd.load_ma = 1'b1;
         ppwm_pkg::ST_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ppwm_pkg::MSEL_POWER;
         end
         ppwm_pkg::ST_MUL_R: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ppwm_pkg::MSEL_RECIP;
         end
         ppwm_pkg::ST_ACC: cmd.accumulate = 1'b1;
         ppwm_pkg::ST_AVG: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ppwm_pkg::MSEL_AVERAGE;
         end
         ppwm_pkg::ST_OUT: cmd.load_rsp = sts.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

### sv/ppwm_datapath.sv
// Datapath with configuration registers, shared multiplier, divide-by-4095 and window state.
`include "panel_power_window_monitor_defines.svh"

module ppwm_datapath #(
   parameter int WINDOW_SAMPLES = ppwm_pkg::DefaultWindowSamples
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ppwm_pkg::cmd_type                   cmd,
   output ppwm_pkg::sts_type                   sts,
   input  logic [ppwm_pkg::CodeWidth-1:0]      raw_volt_code,
   input  logic [ppwm_pkg::CodeWidth-1:0]      raw_amp_code,
   input  logic                                csr_we,
   input  logic [ppwm_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [ppwm_pkg::RegWidth-1:0]       csr_wdata,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [ppwm_pkg::RegWidth-1:0]       volt_mv,
   output logic [ppwm_pkg::RegWidth-1:0]       amp_ma,
   output logic [ppwm_pkg::PowerWidth-1:0]     sample_power_mw,
   output logic [ppwm_pkg::PowerWidth-1:0]     average_power_mw,
   output logic [ppwm_pkg::FaultWidth-1:0]     fault_code,
   output logic                                window_end
);

   localparam int CW = ppwm_pkg::CodeWidth;
   localparam int RW = ppwm_pkg::RegWidth;
   localparam int PW = ppwm_pkg::PowerWidth;
   localparam int MW = ppwm_pkg::MulWidth;
   localparam int SW = ppwm_pkg::SumWidth;
   localparam int IW = ppwm_pkg::IndexWidth;
   localparam int AS = ppwm_pkg::AdcShift;
   localparam int XW = CW + RW + 1;
   localparam int QW = XW + 1 - AS;
   localparam int RemW = XW + 2;
   localparam int AvgShift = SW + $clog2(WINDOW_SAMPLES);
   localparam logic [63:0] AvgRecip =
      ((64'd1 << AvgShift) + 64'(WINDOW_SAMPLES) - 64'd1) / 64'(WINDOW_SAMPLES);

   logic [RW-1:0] fs_volt_ff, fs_amp_ff, volt_limit_ff, amp_limit_ff;
   logic [CW-1:0] vcode_ff, acode_ff;
   logic [ppwm_pkg::ProductWidth-1:0] prod_ff, prod_in;
   logic [MW-1:0] mul_a, mul_b;
   logic [XW-1:0] x_ff, x_in;
   logic [QW-1:0] q0_ff, q0_in;
   logic [XW:0]   s_sum;
   logic [RemW-1:0] rem;
   logic [RW-1:0] quot;
   logic [RW-1:0] mv_ff, ma_ff;
   logic [PW-1:0] pw_ff, pw_in;
   logic [PW-1:0] avg;
   logic [IW-1:0] index_ff;
   logic [SW-1:0] sum_ff;
   logic ov_seen_ff, oc_seen_ff;
   logic rsp_valid_ff;
   logic [RW-1:0] rsp_mv_ff, rsp_ma_ff;
   logic [PW-1:0] rsp_pw_ff, rsp_avg_ff;
   logic [ppwm_pkg::FaultWidth-1:0] rsp_fault_ff;
   logic rsp_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_volt_ff    <= ppwm_pkg::ResetFullScaleVolt;
         fs_amp_ff     <= ppwm_pkg::ResetFullScaleAmp;
         volt_limit_ff <= ppwm_pkg::ResetVoltLimit;
         amp_limit_ff  <= ppwm_pkg::ResetAmpLimit;
      end else if (csr_we) begin
         case (ppwm_pkg::csr_index_type'(csr_index))
            ppwm_pkg::CSR_FULL_SCALE_VOLT: fs_volt_ff    <= csr_wdata;
            ppwm_pkg::CSR_FULL_SCALE_AMP:  fs_amp_ff     <= csr_wdata;
            ppwm_pkg::CSR_VOLT_LIMIT:      volt_limit_ff <= csr_wdata;
            ppwm_pkg::CSR_AMP_LIMIT:       amp_limit_ff  <= csr_wdata;
            default: fs_volt_ff <= fs_volt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         vcode_ff <= raw_volt_code;
         acode_ff <= raw_amp_code;
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         ppwm_pkg::MSEL_VOLT: begin
            mul_a = MW'(vcode_ff);
            mul_b = MW'(fs_volt_ff);
         end
         ppwm_pkg::MSEL_AMP: begin
            mul_a = MW'(acode_ff);
            mul_b = MW'(fs_amp_ff);
         end
         ppwm_pkg::MSEL_POWER: begin
            mul_a = MW'(mv_ff);
            mul_b = MW'(ma_ff);
         end
         ppwm_pkg::MSEL_RECIP: begin
            mul_a = prod_ff[MW-1:0];
            mul_b = ppwm_pkg::Recip1000;
         end
         ppwm_pkg::MSEL_AVERAGE: begin
            mul_a = MW'(sum_ff);
            mul_b = AvgRecip[MW-1:0];
         end
         default: mul_a = '0;
      endcase
   end

   assign prod_in = 64'(mul_a) * 64'(mul_b);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // Rounded division by 2^12 - 1: estimate from the geometric series, then one correction.
   assign x_in  = XW'(prod_ff[XW-2:0]) + XW'(ppwm_pkg::AdcHalf);
   assign s_sum = (XW+1)'(x_in) + (XW+1)'(x_in >> AS) + (XW+1)'(x_in >> (2 * AS));
   assign q0_in = s_sum[XW:AS];

   always_ff @(posedge clock) begin
      x_ff  <= x_in;
      q0_ff <= q0_in;
   end

   assign rem  = RemW'(x_ff) + RemW'(q0_ff) - (RemW'(q0_ff) << AS);
   assign quot = RW'(q0_ff) + RW'(rem >= RemW'(ppwm_pkg::AdcDivisor));

   always_ff @(posedge clock) begin
      if (cmd.load_mv) begin
         mv_ff <= quot;
      end
      if (cmd.load_ma) begin
         ma_ff <= quot;
      end
   end

   assign pw_in = prod_ff[ppwm_pkg::Recip1000Shift +: PW];
   assign avg   = prod_ff[AvgShift +: PW];

   always_ff @(posedge clock) begin
      if (cmd.accumulate) begin
         pw_ff <= pw_in;
      end
   end

   assign sts.window_last = ((IW+1)'(index_ff) + (IW+1)'(1)) >= (IW+1)'(WINDOW_SAMPLES);
   assign sts.rsp_free    = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff   <= '0;
         sum_ff     <= '0;
         ov_seen_ff <= 1'b0;
         oc_seen_ff <= 1'b0;
      end else if (cmd.accumulate) begin
         sum_ff     <= sum_ff + SW'(pw_in);
         ov_seen_ff <= ov_seen_ff || (mv_ff > volt_limit_ff);
         oc_seen_ff <= oc_seen_ff || (ma_ff > amp_limit_ff);
      end else if (cmd.load_rsp) begin
         if (sts.window_last) begin
            index_ff   <= '0;
            sum_ff     <= '0;
            ov_seen_ff <= 1'b0;
            oc_seen_ff <= 1'b0;
         end else begin
            index_ff <= index_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_mv_ff    <= mv_ff;
         rsp_ma_ff    <= ma_ff;
         rsp_pw_ff    <= pw_ff;
         rsp_avg_ff   <= sts.window_last ? avg : '0;
         rsp_fault_ff <= sts.window_last ? {oc_seen_ff, ov_seen_ff} : '0;
         rsp_end_ff   <= sts.window_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign volt_mv          = rsp_mv_ff;
   assign amp_ma           = rsp_ma_ff;
   assign sample_power_mw  = rsp_pw_ff;
   assign average_power_mw = rsp_avg_ff;
   assign fault_code       = rsp_fault_ff;
   assign window_end       = rsp_end_ff;

   `PPWM_ASSERT_ALWAYS(a_index_in_window, index_ff < WINDOW_SAMPLES, "window index out of range")
   `PPWM_ASSERT_IMPLY(a_load_only_when_free, cmd.load_rsp, sts.rsp_free, "result overwritten")
   `PPWM_ASSERT_NEXT(a_window_cleared, cmd.load_rsp && sts.window_last,
      index_ff == '0 && sum_ff == '0 && !ov_seen_ff && !oc_seen_ff, "window state not cleared")
   `PPWM_ASSERT_IMPLY(a_summary_only_at_end, rsp_valid_ff && !rsp_end_ff,
      rsp_fault_ff == '0 && rsp_avg_ff == '0, "window summary outside window end")

endmodule

### sv/panel_power_window_monitor.sv
// Each sample pair steps through the sequencer states from its transfer to its result
// in the output register, with one more state at a window end for the average multiply.
// One 32x32 multiplier is shared by the two scalings, the power product, the divide by
// 1000 and the average, so a new pair is taken only after the last result is loaded.
// A result waits in its output register; the sequencer stalls only if it is still waiting.
// Synchronous active-high reset restores the register defaults and clears the window state.
module panel_power_window_monitor #(
   parameter int WINDOW_SAMPLES = ppwm_pkg::DefaultWindowSamples
) (
   input  logic                               clock,
   input  logic                               reset,
   ppwm_req_if.sink                           req_ch,
   ppwm_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [ppwm_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [ppwm_pkg::RegWidth-1:0]      csr_wdata
);

   ppwm_pkg::cmd_type cmd;
   ppwm_pkg::sts_type sts;

   ppwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ppwm_datapath #(
      .WINDOW_SAMPLES (WINDOW_SAMPLES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .raw_volt_code    (req_ch.raw_volt_code),
      .raw_amp_code     (req_ch.raw_amp_code),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .volt_mv          (rsp_ch.volt_mv),
      .amp_ma           (rsp_ch.amp_ma),
      .sample_power_mw  (rsp_ch.sample_power_mw),
      .average_power_mw (rsp_ch.average_power_mw),
      .fault_code       (rsp_ch.fault_code),
      .window_end       (rsp_ch.window_end)
   );

endmodule
